[rtl/core/rmst_pkg.sv]
// Shared types and constants for the range-minimum segment tree.
package rmst_pkg;

  typedef logic signed [31:0] val_t;

  localparam val_t INT_MAX = 32'sh7FFF_FFFF;

  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

endpackage

[rtl/core/rmst_ram.sv]
// Generic simple dual-port RAM with registered read.
module rmst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/rmst_min.sv]
// Shared signed minimum unit.
module rmst_min
  import rmst_pkg::*;
(
  input  val_t a,
  input  val_t b,
  output val_t y
);

  assign y = (b < a) ? b : a;

endmodule

[rtl/core/range_min_segment_tree.sv]
// Range-minimum segment tree: sequencer, node memory and shared minimum unit.
// Update: busy until the root has been written, no result.
// Query: done pulses when the range walk ends, with
// one node memory read per visited node through the single read port.
// One item at a time; start is taken only while busy is low.
// Reset: synchronous; then a pass writing zero to all 2*LEAVES node addresses holds busy high.
module range_min_segment_tree
  import rmst_pkg::*;
#(
  parameter int LEAVES     = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [9:0]  position,
  input  val_t        new_value,
  input  logic [10:0] range_low,
  input  logic [10:0] range_high,
  output logic        done,
  output val_t        minimum
);

  localparam int LW = $clog2(LEAVES);
  localparam int AW = LW + 1;
  localparam int NW = LW + 2;

  localparam logic [2:0] ST_CLR   = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_UWR   = 3'd2;
  localparam logic [2:0] ST_UWAIT = 3'd3;
  localparam logic [2:0] ST_QL    = 3'd4;
  localparam logic [2:0] ST_QLW   = 3'd5;
  localparam logic [2:0] ST_QR    = 3'd6;
  localparam logic [2:0] ST_QRW   = 3'd7;

  logic [2:0]    state;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] node;
  logic [NW-1:0] l;
  logic [NW-1:0] r;
  val_t          acc;

  logic                         we;
  logic [AW-1:0]                waddr;
  logic [VALUE_BITS-1:0]        wdata;
  logic [AW-1:0]                raddr;
  logic signed [VALUE_BITS-1:0] rd_val;
  logic signed [VALUE_BITS-1:0] new_cut;
  val_t                         rd32;
  val_t                         min_out;
  logic [AW-1:0]                sibling;
  logic [NW-1:0]                lo_n;
  logic [NW-1:0]                hi_n;

  assign busy    = (state != ST_IDLE);
  assign new_cut = VALUE_BITS'(new_value);
  assign rd32    = 32'(rd_val);
  assign sibling = {node[AW-1:1], ~node[0]};

  assign lo_n = (32'(range_low) > 32'(LEAVES)) ? NW'(LEAVES) : NW'(range_low);
  assign hi_n = (32'(range_high) > 32'(LEAVES)) ? NW'(LEAVES) : NW'(range_high);

  rmst_min u_min (
    .a (acc),
    .b (rd32),
    .y (min_out)
  );

  rmst_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (2 * LEAVES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_val)
  );

  always_comb begin
    we    = 1'b0;
    waddr = node;
    wdata = VALUE_BITS'(acc);
    raddr = sibling;
    case (state)
      ST_CLR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = '0;
      end
      ST_UWR: begin
        we = 1'b1;
      end
      ST_QL: begin
        raddr = l[AW-1:0];
      end
      ST_QR: begin
        raddr = AW'(r - NW'(1));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_CLR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            if (kind == KIND_QUERY) begin
              state <= ST_QL;
            end else if (32'(position) < 32'(LEAVES)) begin
              state <= ST_UWR;
            end
          end
        end
        ST_UWR: begin
          if (node == AW'(1)) begin
            state <= ST_IDLE;
          end else begin
            state <= ST_UWAIT;
          end
        end
        ST_UWAIT: state <= ST_UWR;
        ST_QL: begin
          if (l >= r) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end else if (l[0]) begin
            state <= ST_QLW;
          end else begin
            state <= ST_QR;
          end
        end
        ST_QLW: state <= ST_QR;
        ST_QR: begin
          if (r[0]) begin
            state <= ST_QRW;
          end else begin
            state <= ST_QL;
          end
        end
        ST_QRW: state <= ST_QL;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        node <= AW'(position) + AW'(LEAVES);
        l    <= lo_n + NW'(LEAVES);
        r    <= hi_n + NW'(LEAVES);
        if (kind == KIND_QUERY) begin
          acc <= INT_MAX;
        end else begin
          acc <= 32'(new_cut);
        end
      end
      ST_UWAIT: begin
        acc  <= min_out;
        node <= node >> 1;
      end
      ST_QL: begin
        if (l >= r) begin
          minimum <= acc;
        end else if (l[0]) begin
          l <= l + NW'(1);
        end
      end
      ST_QLW: acc <= min_out;
      ST_QR: begin
        if (r[0]) begin
          r <= r - NW'(1);
        end else begin
          l <= l >> 1;
          r <= r >> 1;
        end
      end
      ST_QRW: begin
        acc <= min_out;
        l   <= l >> 1;
        r   <= r >> 1;
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/core/rmst_checker.sv]
// Port-level assertions for the range-minimum segment tree, bound to the top level.
module rmst_checker
  import rmst_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic kind,
  input logic done
);

  logic query_open;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_open <= 1'b0;
    end else if (start && !busy && kind == KIND_QUERY) begin
      query_open <= 1'b1;
    end else if (done) begin
      query_open <= 1'b0;
    end
  end

  a_clear_after_reset: assert property (@(posedge clk) $fell(rst) |-> busy)
    else $error("clearing pass not running after reset");

  a_result_from_query: assert property (@(posedge clk) disable iff (rst)
    done |-> query_open)
    else $error("result without an open query");

  a_result_ends_work: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result while still busy");

  a_query_takes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind == KIND_QUERY) |=> busy && !done)
    else $error("query transfer did not start work");

endmodule

bind range_min_segment_tree rmst_checker u_rmst_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .kind  (kind),
  .done  (done)
);

[verif/range_min_segment_tree_tb.sv]
// Testbench for range_min_segment_tree: directed table, then random updates and queries.
module range_min_segment_tree_tb
  import rmst_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEAF_COUNT   = 1024;
  localparam int RANDOM_ITEMS = 1000;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 200;
  localparam val_t VAL_MIN    = 32'sh8000_0000;

  typedef struct {
    logic        kind;
    logic [9:0]  pos;
    val_t        value;
    logic [10:0] lo;
    logic [10:0] hi;
    bit          typed;
    val_t        want;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        kind;
  logic [9:0]  position;
  val_t        new_value;
  logic [10:0] range_low;
  logic [10:0] range_high;
  logic        done;
  val_t        minimum;

  val_t        leaf_values [LEAF_COUNT];
  val_t        min_expected [16];
  int          exp_wr;
  int          exp_rd;
  int          error_count;
  int          cycle_count;
  int          burst_left;

  // expected minimum typed in only for reset state, empty ranges and extremes
  stim_row_t directed_rows [20] = '{
    '{KIND_QUERY,  10'd0,    '0,           11'd0,    11'd1024, 1'b1, '0},
    '{KIND_QUERY,  10'd0,    '0,           11'd5,    11'd5,    1'b1, INT_MAX},
    '{KIND_QUERY,  10'd0,    '0,           11'd10,   11'd3,    1'b1, INT_MAX},
    '{KIND_QUERY,  10'd0,    '0,           11'd1024, 11'd1024, 1'b1, INT_MAX},
    '{KIND_QUERY,  10'd0,    '0,           11'd2047, 11'd0,    1'b1, INT_MAX},
    '{KIND_QUERY,  10'd0,    '0,           11'd1500, 11'd2047, 1'b1, INT_MAX},
    '{KIND_UPDATE, 10'd0,    VAL_MIN,      11'd0,    11'd0,    1'b0, '0},
    '{KIND_UPDATE, 10'd1023, INT_MAX,      11'd2047, 11'd2047, 1'b0, '0},
    '{KIND_QUERY,  10'd0,    '0,           11'd0,    11'd1,    1'b1, VAL_MIN},
    '{KIND_QUERY,  10'd0,    '0,           11'd1023, 11'd1024, 1'b1, INT_MAX},
    '{KIND_QUERY,  10'd0,    '0,           11'd1023, 11'd2047, 1'b1, INT_MAX},
    '{KIND_QUERY,  10'd0,    '0,           11'd0,    11'd2047, 1'b0, '0},
    '{KIND_UPDATE, 10'd512,  -32'sd1,      11'd0,    11'd0,    1'b0, '0},
    '{KIND_QUERY,  10'd0,    '0,           11'd1,    11'd2047, 1'b0, '0},
    '{KIND_QUERY,  10'd0,    '0,           11'd1,    11'd512,  1'b0, '0},
    '{KIND_UPDATE, 10'd341,  32'sh5555_5555, 11'd0,  11'd0,    1'b0, '0},
    '{KIND_UPDATE, 10'd682,  -32'sh5555_5556, 11'd0, 11'd0,    1'b0, '0},
    '{KIND_QUERY,  10'd0,    '0,           11'd513,  11'd1024, 1'b0, '0},
    '{KIND_QUERY,  10'd0,    '0,           11'd0,    11'd1500, 1'b0, '0},
    '{KIND_QUERY,  10'd0,    '0,           11'd300,  11'd400,  1'b0, '0}
  };

  range_min_segment_tree dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .kind      (kind),
    .position  (position),
    .new_value (new_value),
    .range_low (range_low),
    .range_high(range_high),
    .done      (done),
    .minimum   (minimum)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic expect_minimum(input val_t v);
    min_expected[exp_wr[3:0]] = v;
    exp_wr++;
  endtask

  function automatic val_t range_minimum(input logic [10:0] lo, input logic [10:0] hi);
    int   first;
    int   stop;
    val_t best;
    first = (lo > LEAF_COUNT) ? LEAF_COUNT : int'(lo);
    stop  = (hi > LEAF_COUNT) ? LEAF_COUNT : int'(hi);
    best  = INT_MAX;
    for (int i = first; i < stop; i++) begin
      if (leaf_values[i] < best) best = leaf_values[i];
    end
    return best;
  endfunction

  task automatic idle_gap();
    int n;
    if (burst_left > 0) begin
      burst_left--;
      n = 0;
    end else if ($urandom_range(0, 39) == 0) begin
      burst_left = $urandom_range(10, 30);
      n = 0;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: n = 0;
        4, 5, 6:    n = $urandom_range(1, 3);
        7, 8:       n = $urandom_range(4, 12);
        default:    n = $urandom_range(20, 80);
      endcase
    end
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic run_item(input stim_row_t row);
    start      <= 1'b1;
    kind       <= row.kind;
    position   <= row.pos;
    new_value  <= row.value;
    range_low  <= row.lo;
    range_high <= row.hi;
    do @(posedge clk); while (busy);
    if (row.kind == KIND_UPDATE) begin
      leaf_values[row.pos] = row.value;
    end else if (row.typed) begin
      expect_minimum(row.want);
    end else begin
      expect_minimum(range_minimum(row.lo, row.hi));
    end
  endtask

  function automatic stim_row_t random_row();
    stim_row_t row;
    int        lo;
    int        hi;
    row.typed = 1'b0;
    row.want  = '0;
    row.kind  = ($urandom_range(0, 1) == 0) ? KIND_UPDATE : KIND_QUERY;
    case ($urandom_range(0, 7))
      0:       row.value = INT_MAX;
      1:       row.value = VAL_MIN;
      2, 3:    row.value = int'($urandom_range(0, 200)) - 100;
      default: row.value = $urandom;
    endcase
    case ($urandom_range(0, 4))
      0, 1:    row.pos = 10'($urandom_range(0, 15));
      2:       row.pos = 10'($urandom_range(1008, 1023));
      default: row.pos = 10'($urandom_range(0, 1023));
    endcase
    case ($urandom_range(0, 4))
      0: begin
        lo = $urandom_range(0, 2047);
        hi = $urandom_range(0, 2047);
      end
      1: begin
        lo = $urandom_range(0, 1023);
        hi = lo + $urandom_range(0, 16);
      end
      2: begin
        lo = $urandom_range(0, 20);
        hi = $urandom_range(0, 40);
      end
      3: begin
        lo = $urandom_range(990, 1024);
        hi = $urandom_range(1000, 1100);
      end
      default: begin
        lo = $urandom_range(0, 1024);
        hi = $urandom_range(0, 1024);
      end
    endcase
    row.lo = lo[10:0];
    row.hi = hi[10:0];
    return row;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    val_t want;
    if (!rst && done) begin
      if (exp_wr == exp_rd) begin
        report_mismatch($sformatf("unexpected result minimum=%0d", minimum));
      end else begin
        want = min_expected[exp_rd[3:0]];
        exp_rd++;
        if (minimum !== want) begin
          report_mismatch($sformatf("minimum=%0d want %0d", minimum, want));
        end
      end
    end
  end

  initial begin
    clk         = 1'b0;
    rst         = 1'b1;
    start       = 1'b0;
    kind        = KIND_UPDATE;
    position    = '0;
    new_value   = '0;
    range_low   = '0;
    range_high  = '0;
    exp_wr      = 0;
    exp_rd      = 0;
    error_count = 0;
    cycle_count = 0;
    burst_left  = 0;
    foreach (leaf_values[i]) leaf_values[i] = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      idle_gap();
      run_item(directed_rows[i]);
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idle_gap();
      run_item(random_row());
    end
    start <= 1'b0;

    while (exp_wr != exp_rd) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/rmst_pkg.sv
rtl/core/rmst_ram.sv
rtl/core/rmst_min.sv
rtl/core/range_min_segment_tree.sv
rtl/core/rmst_checker.sv
verif/range_min_segment_tree_tb.sv
